/* rtl/gencnt_pkg.sv */
`timescale 1ns / 1ps

package gencnt_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;

    // column index and row position (row reaches grid_height on the drain row)
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SIZE_W = $clog2(MAX_WIDTH + 1);

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int COUNT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic               is_mine;
        logic [COUNT_W-1:0] mine_count;
        logic               end_of_row;
        logic               end_of_grid;
    } res_t;

endpackage

/* rtl/grid_eight_neighbor_count_core.sv */
`timescale 1ns / 1ps
// channel  | direction | handshake                | payload
// s_       | in        | s_valid / s_ready        | s_op, s_cell_is_mine
// m_       | out       | m_valid / m_ready        | m_out_is_mine, m_mine_count,
//          |           |                          | m_end_of_row, m_end_of_grid
// cfg_     | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one word accepted per cycle while the fifo has room; each word yields zero,
// one or two results, queued in a four-entry output fifo that drains one per
// cycle while m_ready is high; a result reaches m_ through the window stage:
// the line store read registers with the word, the window count writes the fifo
// a row end can push two results, so s_ready drops only when the fifo lacks room
// for two entries; cfg_ready is always high
// synchronous active-low reset; the line store needs no clearing pass since
// rows above the first grid rows are masked by the row position
module grid_eight_neighbor_count_core
    import gencnt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic                  s_cell_is_mine,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_out_is_mine,
    output logic [COUNT_W-1:0]    m_mine_count,
    output logic                  m_end_of_row,
    output logic                  m_end_of_grid,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                     input int maxv);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (int'(v) > maxv) begin
            res = SIZE_W'(maxv);
        end else begin
            res = SIZE_W'(v);
        end
        return res;
    endfunction

    function automatic logic [COUNT_W-1:0] pop9(input logic [8:0] v);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 9; i++) begin
            n = n + COUNT_W'(v[i]);
        end
        return n;
    endfunction

    // configuration
    logic [SIZE_W-1:0] width_reg;
    logic [ROW_W-1:0]  height_reg;

    // position of the next input word
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    // line store: bit 1 = row just above, bit 0 = row two above
    logic [1:0]        line_mem [MAX_WIDTH];
    logic [1:0]        rd_reg;

    // window stage
    logic              st_valid_reg;
    logic [COL_W-1:0]  st_col_reg;
    logic              st_bit_reg;
    logic              st_rge1_reg;
    logic              st_rge2_reg;
    logic              st_cge1_reg;
    logic              st_clast_reg;
    logic              st_eog_reg;
    logic [5:0]        win_reg;

    // output fifo
    res_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;

    logic              s_acc;
    logic              m_pop;
    logic              st_adv;
    logic              fifo_room;
    logic              col_last;
    logic              in_bit;
    logic              up_bit;
    logic              mid_bit;
    logic [2:0]        col_bits;
    logic [5:0]        old_bits;
    logic [8:0]        win0;
    logic [8:0]        win1;
    logic              res0_v;
    logic              res1_v;
    res_t              res0;
    res_t              res1;
    logic [FIFO_AW:0]  n_push;
    logic              bypass;

    assign cfg_ready = 1'b1;

    assign m_pop     = m_valid && m_ready;
    assign fifo_room = ({1'b0, cnt_reg} + (FIFO_AW + 2)'(2))
                       <= ((FIFO_AW + 2)'(FIFO_DEPTH) + (FIFO_AW + 2)'(m_pop));
    assign st_adv    = st_valid_reg && fifo_room;
    assign s_ready   = !st_valid_reg || st_adv;
    assign s_acc     = s_valid && s_ready;

    assign col_last  = (col_reg == COL_W'(width_reg - SIZE_W'(1)));
    assign in_bit    = (row_reg < height_reg) && (s_op == OP_CELL) && s_cell_is_mine;

    always_comb begin
        up_bit   = st_rge2_reg & rd_reg[0];
        mid_bit  = st_rge1_reg & rd_reg[1];
        col_bits = {st_bit_reg, mid_bit, up_bit};
        old_bits = st_cge1_reg ? win_reg : 6'd0;

        // result for the cell one row up and one column left of this word
        win0             = {col_bits, old_bits};
        res0.is_mine     = old_bits[1];
        res0.mine_count  = old_bits[1] ? '0 : pop9(win0);
        res0.end_of_row  = 1'b0;
        res0.end_of_grid = 1'b0;
        res0_v           = st_rge1_reg && st_cge1_reg;

        // result for the last column, no cells to its right
        win1             = {3'b000, col_bits, old_bits[2:0]};
        res1.is_mine     = col_bits[1];
        res1.mine_count  = col_bits[1] ? '0 : pop9(win1);
        res1.end_of_row  = 1'b1;
        res1.end_of_grid = st_eog_reg;
        res1_v           = st_rge1_reg && st_clast_reg;

        n_push = st_adv ? ((FIFO_AW + 1)'(res0_v) + (FIFO_AW + 1)'(res1_v)) : '0;
    end

    assign bypass = st_adv && (st_col_reg == col_reg);

    // line store: read at accept, written when the word leaves the window stage
    always_ff @(posedge aclk) begin
        if (st_adv) begin
            line_mem[st_col_reg] <= {st_bit_reg, mid_bit};
        end
        if (s_acc) begin
            rd_reg <= bypass ? {st_bit_reg, mid_bit} : line_mem[col_reg];
        end
    end

    // configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(MAX_WIDTH);
            height_reg <= ROW_W'(MAX_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_GRID_WIDTH) begin
                width_reg <= clamp_size(cfg_data, MAX_WIDTH);
                col_reg   <= '0;
                row_reg   <= '0;
            end else if (cfg_index == CFG_GRID_HEIGHT) begin
                height_reg <= ROW_W'(clamp_size(cfg_data, MAX_HEIGHT));
                col_reg    <= '0;
                row_reg    <= '0;
            end
        end else if (s_acc) begin
            if (col_last) begin
                col_reg <= '0;
                row_reg <= (row_reg >= height_reg) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // window stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready && (cfg_index == CFG_GRID_WIDTH
                                           || cfg_index == CFG_GRID_HEIGHT)) begin
                win_reg <= '0;
            end else if (st_adv) begin
                win_reg <= {old_bits[2:0], col_bits};
            end
            if (s_acc) begin
                st_valid_reg <= 1'b1;
            end else if (st_adv) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st_col_reg   <= col_reg;
            st_bit_reg   <= in_bit;
            st_rge1_reg  <= (row_reg >= ROW_W'(1));
            st_rge2_reg  <= (row_reg >= ROW_W'(2));
            st_cge1_reg  <= (col_reg != '0);
            st_clast_reg <= col_last;
            st_eog_reg   <= (row_reg == height_reg);
        end
    end

    // output fifo
    always_ff @(posedge aclk) begin
        if (st_adv) begin
            if (res0_v) begin
                fifo_mem[wr_ptr_reg] <= res0;
            end
            if (res1_v) begin
                fifo_mem[wr_ptr_reg + FIFO_AW'(res0_v)] <= res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(n_push);
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            cnt_reg <= cnt_reg + n_push - (FIFO_AW + 1)'(m_pop);
        end
    end

    assign m_valid       = (cnt_reg != '0);
    assign m_out_is_mine = fifo_mem[rd_ptr_reg].is_mine;
    assign m_mine_count  = fifo_mem[rd_ptr_reg].mine_count;
    assign m_end_of_row  = fifo_mem[rd_ptr_reg].end_of_row;
    assign m_end_of_grid = fifo_mem[rd_ptr_reg].end_of_grid;

endmodule

/* rtl/gencnt_checker.sv */
`timescale 1ns / 1ps

module gencnt_checker
    import gencnt_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_out_is_mine,
    input logic [COUNT_W-1:0]    m_mine_count,
    input logic                  m_end_of_row,
    input logic                  m_end_of_grid
);

    // a stalled result word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_is_mine)
            && $stable(m_mine_count) && $stable(m_end_of_row) && $stable(m_end_of_grid))
        else $error("result word changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_mine_count <= COUNT_W'(8))
        else $error("neighbor count above eight");

    a_mine_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_is_mine |-> m_mine_count == '0)
        else $error("mine cell with nonzero count");

    a_eog_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_grid |-> m_end_of_row)
        else $error("grid end not on a row end");

endmodule

bind grid_eight_neighbor_count_core gencnt_checker u_gencnt_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import gencnt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;
    localparam int PIPE_SETTLE = 10;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_WORDS = 200;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_op = OP_CELL;
    logic                  s_cell_is_mine = 1'b0;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_out_is_mine;
    logic [COUNT_W-1:0]    m_mine_count;
    logic                  m_end_of_row;
    logic                  m_end_of_grid;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic sink_ready = 1'b0;
    logic hold_off = 1'b0;
    bit   src_burst = 1'b0;
    bit   sink_burst = 1'b0;
    int   hold_request = 0;

    // expected results and the tracked state of the grid scan
    res_t        expected_cells[$];
    logic        upper_row[MAX_WIDTH];
    logic        middle_row[MAX_WIDTH];
    int unsigned col_at = 0;
    int unsigned row_at = 0;
    logic [5:0]  left_bits = '0;
    logic [7:0]  width_reg = 8'd128;
    logic [7:0]  height_reg = 8'd128;

    int errors = 0;
    int words_sent = 0;
    int results_checked = 0;
    int grids_run = 0;
    int cfg_writes = 0;

    assign m_ready = sink_ready && !hold_off;

    grid_eight_neighbor_count_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_cell_is_mine (s_cell_is_mine),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_is_mine  (m_out_is_mine),
        .m_mine_count   (m_mine_count),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_grid  (m_end_of_grid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned eff_size(input logic [7:0] v, input int unsigned cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic res_t neighbor_result(input logic [8:0] win, input logic center,
                                             input logic eor, input logic eog);
        res_t r;
        int n;
        n = 0;
        for (int i = 0; i < 9; i++) n += win[i];
        r.is_mine     = center;
        r.mine_count  = center ? '0 : COUNT_W'(n);
        r.end_of_row  = eor;
        r.end_of_grid = eog;
        return r;
    endfunction

    // one accepted word: queue the results it releases and slide the window
    function automatic void advance_grid(input logic op, input logic mine);
        int unsigned w, h, c, r;
        logic cur_bit, up, mid;
        logic [2:0] column;
        logic [5:0] prior;
        w = eff_size(width_reg, MAX_WIDTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        c = (col_at >= w) ? 0 : col_at;
        r = row_at;
        cur_bit = (r < h && op == OP_CELL) ? mine : 1'b0;
        up = (r >= 2) ? upper_row[c] : 1'b0;
        mid = (r >= 1) ? middle_row[c] : 1'b0;
        column = {cur_bit, mid, up};
        prior = (c == 0) ? 6'd0 : left_bits;
        if (r >= 1) begin
            // cell one up and one left is now complete
            if (c >= 1)
                expected_cells.push_back(neighbor_result({column, prior}, prior[1],
                                                         1'b0, 1'b0));
            // last column has no right neighbor, so it closes right away
            if (c == w - 1)
                expected_cells.push_back(neighbor_result({3'b000, column, prior[2:0]},
                                                         column[1], 1'b1, r == h));
        end
        upper_row[c] = mid;
        middle_row[c] = cur_bit;
        left_bits = {prior[2:0], column};
        c++;
        if (c >= w) begin
            c = 0;
            r = (r >= h) ? 0 : r + 1;
        end
        col_at = c;
        row_at = r;
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    function automatic logic [7:0] draw_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'($urandom_range(13, 40));
        return 8'($urandom_range(1, 12));
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual mine=%0d count=%0d",
                         $time, m_out_is_mine, m_mine_count);
                errors++;
            end else begin
                want = expected_cells.pop_front();
                results_checked++;
                check_field("out_is_mine", want.is_mine, m_out_is_mine);
                check_field("mine_count", want.mine_count, m_mine_count);
                check_field("end_of_row", want.end_of_row, m_end_of_row);
                check_field("end_of_grid", want.end_of_grid, m_end_of_grid);
            end
        end
    end

    // result side: random stall per word
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                sink_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            sink_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // long hold-off on the result side, counted here
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_off <= 1'b1;
                repeat (hold_request) @(posedge aclk);
                hold_off <= 1'b0;
                hold_request = 0;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("grid_eight_neighbor_count_core regression: fail");
        $finish;
    end

    task automatic send_word(input logic op, input logic mine);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_cell_is_mine <= mine;
        do @(posedge aclk); while (!s_ready);
        advance_grid(op, mine);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_GRID_WIDTH || idx == CFG_GRID_HEIGHT) begin
            if (idx == CFG_GRID_WIDTH)
                width_reg = data;
            else
                height_reg = data;
            // any size write restarts the scan
            col_at = 0;
            row_at = 0;
            left_bits = '0;
        end
        cfg_writes++;
        @(posedge aclk);
    endtask

    // wait out queued results plus words still in the pipe that give none
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // raster scan of a grid followed by its drain row, cut short after words
    task automatic run_grid(input int cols, input int rows, input int pct,
                            input bit noisy, input int words);
        int n;
        logic op;
        n = 0;
        grids_run++;
        for (int r = 0; r <= rows && n < words; r++) begin
            for (int c = 0; c < cols && n < words; c++) begin
                if (r < rows)
                    op = (noisy && $urandom_range(0, 15) == 0) ? OP_DRAIN : OP_CELL;
                else
                    op = (noisy && $urandom_range(0, 3) == 0) ? OP_CELL : OP_DRAIN;
                send_word(op, $urandom_range(0, 99) < pct);
                n++;
            end
        end
    endtask

    // reset sizes are 128: 130 words reach the first result
    task automatic test_reset_size();
        run_grid(128, 128, 50, 1'b0, 130);
    endtask

    task automatic test_directed();
        settle();
        write_reg(CFG_GRID_WIDTH, 8'd3);
        write_reg(CFG_GRID_HEIGHT, 8'd2);
        send_word(OP_CELL, 1'b1);
        send_word(OP_CELL, 1'b0);
        send_word(OP_CELL, 1'b1);
        // drain word inside the grid counts as empty
        send_word(OP_CELL, 1'b0);
        send_word(OP_DRAIN, 1'b1);
        send_word(OP_CELL, 1'b1);
        // mine on a cell word in the drain row is ignored
        send_word(OP_DRAIN, 1'b0);
        send_word(OP_CELL, 1'b1);
        send_word(OP_DRAIN, 1'b1);
        settle();
        // restart in the middle of a grid
        write_reg(CFG_GRID_WIDTH, 8'd2);
        send_word(OP_CELL, 1'b1);
        send_word(OP_CELL, 1'b1);
        send_word(OP_CELL, 1'b1);
        settle();
        // empty center ringed by mines, with a write to an unused index mid-grid
        write_reg(CFG_GRID_WIDTH, 8'd3);
        write_reg(CFG_GRID_HEIGHT, 8'd3);
        repeat (3) send_word(OP_CELL, 1'b1);
        settle();
        write_reg(CFG_UNUSED, 8'hff);
        send_word(OP_CELL, 1'b1);
        send_word(OP_CELL, 1'b0);
        send_word(OP_CELL, 1'b1);
        repeat (3) send_word(OP_CELL, 1'b1);
        repeat (3) send_word(OP_DRAIN, 1'b0);
        settle();
        // zero sizes act as a single cell
        write_reg(CFG_GRID_WIDTH, 8'd0);
        write_reg(CFG_GRID_HEIGHT, 8'd0);
        send_word(OP_CELL, 1'b1);
        send_word(OP_DRAIN, 1'b0);
    endtask

    task automatic test_size_extremes();
        settle();
        write_reg(CFG_GRID_WIDTH, 8'd255);
        write_reg(CFG_GRID_HEIGHT, 8'd1);
        run_grid(MAX_WIDTH, 1, 50, 1'b1, (1 + 1) * MAX_WIDTH);
        settle();
        write_reg(CFG_GRID_WIDTH, 8'd1);
        write_reg(CFG_GRID_HEIGHT, 8'd200);
        run_grid(1, MAX_HEIGHT, 60, 1'b1, MAX_HEIGHT + 1);
    endtask

    // receiver holds off while the sender keeps pushing, fifo fills up
    task automatic test_backpressure();
        settle();
        write_reg(CFG_GRID_WIDTH, 8'd8);
        write_reg(CFG_GRID_HEIGHT, 8'd6);
        src_burst = 1'b1;
        hold_request = 150;
        run_grid(8, 6, 40, 1'b0, 7 * 8);
        src_burst = 1'b0;
    endtask

    task automatic test_random_grids();
        int total, cut, pct, sel, sent;
        int unsigned cols, rows;
        bit complete, reuse;
        logic [7:0] wv, hv;
        sent = 0;
        complete = 1'b0;
        wv = 8'd1;
        hv = 8'd1;
        while (sent < RANDOM_WORDS) begin
            // back-to-back grids rely on the wrap after the drain row
            reuse = complete && $urandom_range(0, 2) == 0;
            if (!reuse) begin
                settle();
                wv = draw_size();
                hv = draw_size();
                write_reg(CFG_GRID_WIDTH, wv);
                write_reg(CFG_GRID_HEIGHT, hv);
            end
            cols = eff_size(wv, MAX_WIDTH);
            rows = eff_size(hv, MAX_HEIGHT);
            total = (rows + 1) * cols;
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
            if (cut > RANDOM_WORDS - sent)
                cut = RANDOM_WORDS - sent;
            sel = $urandom_range(0, 5);
            pct = (sel == 0) ? 0 : (sel == 1) ? 100 : $urandom_range(10, 90);
            src_burst = $urandom_range(0, 3) == 0;
            sink_burst = $urandom_range(0, 3) == 0;
            run_grid(cols, rows, pct, 1'b1, cut);
            sent += cut;
            complete = (cut == total);
        end
        src_burst = 1'b0;
        sink_burst = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i] = 1'b0;
            middle_row[i] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_size();
        test_directed();
        test_size_extremes();
        test_backpressure();
        test_random_grids();

        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d words in %0d grids, %0d results checked, %0d config writes",
                 words_sent, grids_run, results_checked, cfg_writes);
        $display("mismatches seen: %0d", errors);
        if (errors == 0)
            $display("grid_eight_neighbor_count_core regression: pass");
        else
            $display("grid_eight_neighbor_count_core regression: fail");
        $finish;
    end

endmodule
